FILE: rtl/assert_macros.svh
// Assertion macros used by the scanner output stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ETS assertion failed");

// Next-cycle implication, disabled during reset.
`define ETS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ETS assertion failed");

`endif

FILE: rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Types, token codes and character constants of the expression scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

    localparam int MAX_IDENT_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF   = 24;
    localparam int POS_MAX_BITS        = 32;

    localparam logic [3:0] K_CHAR   = 4'd0;
    localparam logic [3:0] K_NUMBER = 4'd1;
    localparam logic [3:0] K_IDENT  = 4'd2;
    localparam logic [3:0] K_IF     = 4'd3;
    localparam logic [3:0] K_ELSE   = 4'd4;
    localparam logic [3:0] K_THEN   = 4'd5;
    localparam logic [3:0] K_NE     = 4'd6;
    localparam logic [3:0] K_EQ     = 4'd7;
    localparam logic [3:0] K_LE     = 4'd8;
    localparam logic [3:0] K_GE     = 4'd9;
    localparam logic [3:0] K_END    = 4'd10;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_N     = 8'h6E;

    typedef struct packed {
        logic [3:0]              kind;
        logic [7:0]              ch;
        logic [POS_MAX_BITS-1:0] pos;
        logic [63:0]             sig;
        logic [15:0]             dexp;
        logic [63:0]             text;
        logic [3:0]              len;
        logic                    ovf;
        logic                    last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

`default_nettype wire

FILE: rtl/ets_scan_core.sv
// ----------------------------------------------------------------------------
// ets_scan_core
// Scanner state and the single-pass next-state and token logic for one
// request.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_scan_core #(
    parameter int MAX_IDENT_CHARS = ets_pkg::MAX_IDENT_CHARS_DEF,
    parameter int POSITION_BITS   = ets_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_character,
    input  wire logic          i_end_of_text,
    output ets_pkg::t_push     o_push
);

    localparam int CW = $clog2(MAX_IDENT_CHARS + 1);
    localparam int PB = POSITION_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_COMMENT, S_INT, S_FRAC, S_EXP_START, S_EXP_DIGITS, S_IDENT, S_OP
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [7:0]        r_pend, n_pend;
    logic [PB-1:0]     r_cpos, n_cpos;
    logic [PB-1:0]     r_start, n_start;
    logic [63:0]       r_acc, n_acc;
    logic [15:0]       r_frac, n_frac;
    logic [14:0]       r_exp, n_exp;
    logic              r_neg, n_neg;
    logic [7:0]        r_buf [MAX_IDENT_CHARS];
    logic [7:0]        n_buf [MAX_IDENT_CHARS];
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_ovf, n_ovf;

    logic              is_digit, is_alpha, is_space, is_opc;
    logic [67:0]       acc_mul;
    logic              acc_sat;
    logic [63:0]       acc_next;
    logic [19:0]       exp_mul;
    logic              exp_sat;
    logic [14:0]       exp_next;
    logic signed [17:0] e_full;
    logic [15:0]       e_clip;
    logic              e_ovf;
    logic [63:0]       id_text;
    logic [3:0]        id_kind;
    ets_pkg::t_token   num_tok, id_tok, opc_tok, op2_tok, chr_tok, end_tok;

    always_comb begin
        is_digit = (i_character >= 8'h30) && (i_character <= 8'h39);
        is_alpha = ((i_character >= 8'h61) && (i_character <= 8'h7A)) ||
                   ((i_character >= 8'h41) && (i_character <= 8'h5A));
        is_space = (i_character == ets_pkg::CH_SPACE) ||
                   ((i_character >= 8'd9) && (i_character <= 8'd13));
        is_opc   = (i_character == ets_pkg::CH_BANG) || (i_character == ets_pkg::CH_EQ) ||
                   (i_character == ets_pkg::CH_LT) || (i_character == ets_pkg::CH_GT);

        acc_mul  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {64'b0, i_character[3:0]};
        acc_sat  = |acc_mul[67:64];
        acc_next = acc_sat ? '1 : acc_mul[63:0];

        exp_mul  = ({5'b0, r_exp} << 3) + ({5'b0, r_exp} << 1) + {16'b0, i_character[3:0]};
        exp_sat  = exp_mul > 20'd32767;
        exp_next = exp_sat ? 15'h7FFF : exp_mul[14:0];

        e_full = (r_neg ? -$signed({3'b0, r_exp}) : $signed({3'b0, r_exp}))
                 - $signed({2'b0, r_frac});
        e_ovf  = 1'b0;
        if (e_full < -18'sd32768) begin
            e_clip = 16'h8000;
            e_ovf  = 1'b1;
        end else if (e_full > 18'sd32767) begin
            e_clip = 16'h7FFF;
            e_ovf  = 1'b1;
        end else begin
            e_clip = e_full[15:0];
        end

        id_text = '0;
        for (int i = 0; i < MAX_IDENT_CHARS; i++) begin
            if (CW'(i) < r_cnt) begin
                id_text[8*i +: 8] = r_buf[i];
            end
        end
        id_kind = ets_pkg::K_IDENT;
        if (!r_ovf && r_cnt == CW'(2) && r_buf[0] == ets_pkg::CH_I &&
            r_buf[1] == ets_pkg::CH_F) begin
            id_kind = ets_pkg::K_IF;
        end else if (!r_ovf && r_cnt == CW'(4) && r_buf[0] == ets_pkg::CH_E &&
                     r_buf[1] == ets_pkg::CH_L && r_buf[2] == ets_pkg::CH_S &&
                     r_buf[3] == ets_pkg::CH_E) begin
            id_kind = ets_pkg::K_ELSE;
        end else if (!r_ovf && r_cnt == CW'(4) && r_buf[0] == ets_pkg::CH_T &&
                     r_buf[1] == ets_pkg::CH_H && r_buf[2] == ets_pkg::CH_E &&
                     r_buf[3] == ets_pkg::CH_N) begin
            id_kind = ets_pkg::K_THEN;
        end

        num_tok      = '0;
        num_tok.kind = ets_pkg::K_NUMBER;
        num_tok.pos  = ets_pkg::POS_MAX_BITS'(r_start);
        num_tok.sig  = r_acc;
        num_tok.dexp = e_clip;
        num_tok.ovf  = r_ovf | e_ovf;

        id_tok      = '0;
        id_tok.kind = id_kind;
        id_tok.pos  = ets_pkg::POS_MAX_BITS'(r_start);
        id_tok.text = id_text;
        id_tok.len  = 4'(r_cnt);
        id_tok.ovf  = r_ovf;

        opc_tok      = '0;
        opc_tok.kind = ets_pkg::K_CHAR;
        opc_tok.ch   = r_pend;
        opc_tok.pos  = ets_pkg::POS_MAX_BITS'(r_start);

        op2_tok     = '0;
        op2_tok.pos = ets_pkg::POS_MAX_BITS'(r_start);
        if (r_pend == ets_pkg::CH_BANG) begin
            op2_tok.kind = ets_pkg::K_NE;
        end else if (r_pend == ets_pkg::CH_EQ) begin
            op2_tok.kind = ets_pkg::K_EQ;
        end else if (r_pend == ets_pkg::CH_LT) begin
            op2_tok.kind = ets_pkg::K_LE;
        end else begin
            op2_tok.kind = ets_pkg::K_GE;
        end

        chr_tok      = '0;
        chr_tok.kind = ets_pkg::K_CHAR;
        chr_tok.ch   = i_character;
        chr_tok.pos  = ets_pkg::POS_MAX_BITS'(r_cpos);
        chr_tok.last = 1'b1;

        end_tok      = '0;
        end_tok.kind = ets_pkg::K_END;
        end_tok.pos  = ets_pkg::POS_MAX_BITS'(r_cpos);
        end_tok.last = 1'b1;
    end

    logic            have_flush, have_second, used, do_clear;
    ets_pkg::t_token flush_tok, second_tok;

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_cpos  = r_cpos;
        n_start = r_start;
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_exp   = r_exp;
        n_neg   = r_neg;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        have_flush  = 1'b0;
        have_second = 1'b0;
        flush_tok   = '0;
        second_tok  = '0;
        used        = 1'b0;
        do_clear    = 1'b0;

        if (i_fire && i_end_of_text) begin
            unique case (r_mode)
                S_INT, S_FRAC, S_EXP_START, S_EXP_DIGITS: begin
                    have_flush = 1'b1;
                    flush_tok  = num_tok;
                end
                S_IDENT: begin
                    have_flush = 1'b1;
                    flush_tok  = id_tok;
                end
                S_OP: begin
                    have_flush = 1'b1;
                    flush_tok  = opc_tok;
                end
                default: begin
                end
            endcase
            have_second = 1'b1;
            second_tok  = end_tok;
            do_clear    = 1'b1;
            n_cpos      = '0;
            n_start     = '0;
        end else if (i_fire) begin
            n_cpos = r_cpos + PB'(1);
            unique case (r_mode)
                S_COMMENT: begin
                    if (i_character == ets_pkg::CH_LF) begin
                        n_mode = S_IDLE;
                    end
                    used = 1'b1;
                end
                S_INT: begin
                    if (is_digit) begin
                        n_acc = acc_next;
                        n_ovf = r_ovf | acc_sat;
                        used  = 1'b1;
                    end else if (i_character == ets_pkg::CH_DOT) begin
                        n_mode = S_FRAC;
                        used   = 1'b1;
                    end else if (i_character == ets_pkg::CH_E) begin
                        n_mode = S_EXP_START;
                        used   = 1'b1;
                    end else begin
                        have_flush = 1'b1;
                        flush_tok  = num_tok;
                        do_clear   = 1'b1;
                    end
                end
                S_FRAC: begin
                    if (is_digit) begin
                        n_acc  = acc_next;
                        n_frac = (r_frac == 16'hFFFF) ? r_frac : r_frac + 16'd1;
                        n_ovf  = r_ovf | acc_sat | (r_frac == 16'hFFFF);
                        used   = 1'b1;
                    end else if (i_character == ets_pkg::CH_E) begin
                        n_mode = S_EXP_START;
                        used   = 1'b1;
                    end else begin
                        have_flush = 1'b1;
                        flush_tok  = num_tok;
                        do_clear   = 1'b1;
                    end
                end
                S_EXP_START: begin
                    if (i_character == ets_pkg::CH_MINUS) begin
                        n_neg  = 1'b1;
                        n_mode = S_EXP_DIGITS;
                        used   = 1'b1;
                    end else if (i_character == ets_pkg::CH_PLUS) begin
                        n_mode = S_EXP_DIGITS;
                        used   = 1'b1;
                    end else if (is_digit) begin
                        n_exp  = exp_next;
                        n_ovf  = r_ovf | exp_sat;
                        n_mode = S_EXP_DIGITS;
                        used   = 1'b1;
                    end else begin
                        have_flush = 1'b1;
                        flush_tok  = num_tok;
                        do_clear   = 1'b1;
                    end
                end
                S_EXP_DIGITS: begin
                    if (is_digit) begin
                        n_exp = exp_next;
                        n_ovf = r_ovf | exp_sat;
                        used  = 1'b1;
                    end else begin
                        have_flush = 1'b1;
                        flush_tok  = num_tok;
                        do_clear   = 1'b1;
                    end
                end
                S_IDENT: begin
                    if (is_alpha || is_digit) begin
                        if (r_cnt < CW'(MAX_IDENT_CHARS)) begin
                            for (int i = 0; i < MAX_IDENT_CHARS; i++) begin
                                if (CW'(i) == r_cnt) begin
                                    n_buf[i] = i_character;
                                end
                            end
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        used = 1'b1;
                    end else begin
                        have_flush = 1'b1;
                        flush_tok  = id_tok;
                        do_clear   = 1'b1;
                    end
                end
                S_OP: begin
                    have_flush = 1'b1;
                    if (i_character == ets_pkg::CH_EQ) begin
                        flush_tok = op2_tok;
                        used      = 1'b1;
                    end else begin
                        flush_tok = opc_tok;
                    end
                    do_clear = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_clear) begin
            n_mode = S_IDLE;
            n_pend = '0;
            n_acc  = '0;
            n_frac = '0;
            n_exp  = '0;
            n_neg  = 1'b0;
            n_cnt  = '0;
            n_ovf  = 1'b0;
        end

        if (i_fire && !i_end_of_text && !used) begin
            if (is_space) begin
            end else if (i_character == ets_pkg::CH_HASH) begin
                n_mode = S_COMMENT;
            end else if (is_digit) begin
                n_start = r_cpos;
                n_acc   = {60'b0, i_character[3:0]};
                n_mode  = S_INT;
            end else if (is_alpha) begin
                n_start  = r_cpos;
                n_buf[0] = i_character;
                n_cnt    = CW'(1);
                n_mode   = S_IDENT;
            end else if (is_opc) begin
                n_start = r_cpos;
                n_pend  = i_character;
                n_mode  = S_OP;
            end else begin
                have_second = 1'b1;
                second_tok  = chr_tok;
            end
        end

        flush_tok.last = !have_second;
        if (have_flush) begin
            o_push.tok0  = flush_tok;
            o_push.tok1  = second_tok;
            o_push.count = have_second ? 2'd2 : 2'd1;
        end else begin
            o_push.tok0  = second_tok;
            o_push.tok1  = '0;
            o_push.count = have_second ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_pend  <= '0;
            r_cpos  <= '0;
            r_start <= '0;
            r_acc   <= '0;
            r_frac  <= '0;
            r_exp   <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_cpos  <= n_cpos;
            r_start <= n_start;
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_exp   <= n_exp;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ets_out_stage.sv
// ----------------------------------------------------------------------------
// ets_out_stage
// Two-slot result register: the presented token and one waiting token.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ets_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire ets_pkg::t_push i_push,
    input  wire logic           i_ready,
    output logic                o_room,
    output logic                o_valid,
    output ets_pkg::t_token     o_tok
);

    logic            r_v0, r_v1;
    ets_pkg::t_token r_t0, r_t1;
    logic            pop, push;

    assign pop    = r_v0 && i_ready;
    assign push   = i_fire && (i_push.count != 2'd0);
    assign o_room = !r_v1 && (!r_v0 || i_ready);
    assign o_valid = r_v0;
    assign o_tok   = r_t0;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_t0 <= i_push.tok0;
            r_t1 <= i_push.tok1;
        end else if (pop) begin
            r_t0 <= r_t1;
        end
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (push) begin
            r_v0 <= 1'b1;
            r_v1 <= (i_push.count == 2'd2);
        end else if (pop) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end
    end

    `ETS_ASSERT_IMPLY(a_slot_order, i_clk, i_rst_n, r_v1, r_v0)
    `ETS_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, push, o_room)
    `ETS_ASSERT_NEXT(a_pair_held, i_clk, i_rst_n, push && (i_push.count == 2'd2), r_v1)

endmodule

`default_nettype wire

FILE: rtl/expression_token_scanner.sv
// A character is captured in the input register; once the output stage has room, its
// first token is written into the presented output slot register.
// Throughput: one character per cycle while i_ready is high; an item that causes two tokens
// holds input until the waiting token moves up: a new item is processed only when both tokens fit.
// Reset (i_rst_n low, synchronous) empties both stages and returns the scanner
// to the between-tokens state with position zero.
// ----------------------------------------------------------------------------
// expression_token_scanner
// Streaming tokenizer for expression text with numbers, identifiers, keywords
// and comparison operators.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_token_scanner #(
    parameter int MAX_IDENT_CHARS = ets_pkg::MAX_IDENT_CHARS_DEF,
    parameter int POSITION_BITS   = ets_pkg::POSITION_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_character,
    input  wire logic                      i_end_of_text,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [3:0]                     o_token_kind,
    output logic [7:0]                     o_token_char,
    output logic [POSITION_BITS-1:0]       o_token_position,
    output logic [63:0]                    o_significand,
    output logic signed [15:0]             o_decimal_exponent,
    output logic [63:0]                    o_ident_text,
    output logic [3:0]                     o_ident_length,
    output logic                           o_overflow,
    output logic                           o_last
);

    logic            r_in_v;
    logic [7:0]      r_in_char;
    logic            r_in_eot;
    logic            fire, room;
    ets_pkg::t_push  push;
    ets_pkg::t_token tok;

    assign fire    = r_in_v && room;
    assign o_ready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_character;
            r_in_eot  <= i_end_of_text;
        end
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    ets_scan_core #(
        .MAX_IDENT_CHARS (MAX_IDENT_CHARS),
        .POSITION_BITS   (POSITION_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_character   (r_in_char),
        .i_end_of_text (r_in_eot),
        .o_push        (push)
    );

    ets_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_push  (push),
        .i_ready (i_ready),
        .o_room  (room),
        .o_valid (o_valid),
        .o_tok   (tok)
    );

    assign o_token_kind       = tok.kind;
    assign o_token_char       = tok.ch;
    assign o_token_position   = tok.pos[POSITION_BITS-1:0];
    assign o_significand      = tok.sig;
    assign o_decimal_exponent = tok.dexp;
    assign o_ident_text       = tok.text;
    assign o_ident_length     = tok.len;
    assign o_overflow         = tok.ovf;
    assign o_last             = tok.last;

endmodule

`default_nettype wire
